FILE: rtl/mntag_pkg.sv
// Shared types and constants for the mesh node table with aging.
package mntag_pkg;

   // Width of a node id.
   localparam int ID_W = 7;

   // Input opcodes.
   localparam logic [1:0] OP_RECORD = 2'd0;
   localparam logic [1:0] OP_EMPTY  = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;

   // Result kinds.
   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_RELAY  = 2'd1;
   localparam logic [1:0] KIND_IDLE   = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] REG_OWN_ID    = 2'd0;
   localparam logic [1:0] REG_OWN_LREF  = 2'd1;
   localparam logic [1:0] REG_TIMEOUT   = 2'd2;
   localparam logic [1:0] REG_THRESHOLD = 2'd3;

   // Register values after reset, and the miss counter limit.
   localparam logic [30:0] TIMEOUT_RESET   = 31'd1000;
   localparam logic [7:0]  THRESHOLD_RESET = 8'd10;
   localparam logic [7:0]  MISS_MAX        = 8'hFF;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] now_ms;
      logic [6:0]  node_id;
      logic [31:0] record_time;
      logic [15:0] record_ref;
      logic        record_origin;
      logic        packet_last;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [6:0]  out_node_id;
      logic [31:0] out_time;
      logic [15:0] out_ref;
      logic        relay_origin;
      logic        source_heard;
      logic [4:0]  active_count;
      logic        restart_request;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [6:0]  own_id;
      logic [15:0] own_lref;
      logic [30:0] timeout;
      logic [7:0]  threshold;
   } cfg_type;

   // One table entry; arrival is the local time at which the record came in.
   typedef struct packed {
      logic [31:0] stamp;
      logic [15:0] lref;
      logic        source;
      logic [31:0] arrival;
   } entry_type;

   typedef struct packed {
      logic      rd_en;
      logic      wr_en;
      entry_type wr_data;
   } tbl_cmd_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [31:0] diff;
      logic        borrow;
   } alu_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REC_READ,
      ST_REC_CMP,
      ST_STATUS,
      ST_OWN,
      ST_ACT_RD,
      ST_ACT_DIFF,
      ST_ACT_CMP,
      ST_NONE,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } state_type;

endpackage

FILE: rtl/mntag_alu.sv
// Shared 32-bit subtractor used for timestamp and activity compares.
module mntag_alu
   import mntag_pkg::*;
(
   input  alu_req_type alu_req,
   output alu_rsp_type alu_rsp
);

   logic [32:0] result;

   // The borrow out is set when a is below b, both read unsigned.
   assign result         = {1'b0, alu_req.a} - {1'b0, alu_req.b};
   assign alu_rsp.diff   = result[31:0];
   assign alu_rsp.borrow = result[32];

endmodule

FILE: rtl/mntag_store.sv
// Node table storage: entry memory with registered read and per-entry valid bits.
module mntag_store
   import mntag_pkg::*;
#(
   parameter  int TABLE_NODES = 16,
   localparam int IDX_W       = $clog2(TABLE_NODES)
) (
   input  logic             clock,
   input  logic             reset,
   input  tbl_cmd_type      tbl_cmd,
   input  logic [IDX_W-1:0] tbl_addr,
   output entry_type        rd_data,
   output logic             rd_valid
);

   entry_type              mem_ff [TABLE_NODES];
   entry_type              rd_data_ff;
   logic                   rd_valid_ff;
   logic [TABLE_NODES-1:0] valid_ff;

   // Entry memory: one write and one read per cycle, read data registered.
   always_ff @(posedge clock) begin
      if (tbl_cmd.wr_en) begin
         mem_ff[tbl_addr] <= tbl_cmd.wr_data;
      end
      if (tbl_cmd.rd_en) begin
         rd_data_ff <= mem_ff[tbl_addr];
      end
   end

   // Valid bits are cleared together at reset; every write marks its entry.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (tbl_cmd.wr_en) begin
            valid_ff[tbl_addr] <= 1'b1;
         end
         if (tbl_cmd.rd_en) begin
            rd_valid_ff <= valid_ff[tbl_addr];
         end
      end
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;

endmodule

FILE: rtl/mntag_ctrl.sv
// Sequencer for record updates, packet-end miss counting and the tick walk.
module mntag_ctrl
   import mntag_pkg::*;
#(
   parameter  int TABLE_NODES = 16,
   localparam int IDX_W       = $clog2(TABLE_NODES),
   localparam int CNT_W       = $clog2(TABLE_NODES + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  cfg_type          cfg,
   output tbl_cmd_type      tbl_cmd,
   output logic [IDX_W-1:0] tbl_addr,
   input  entry_type        rd_data,
   input  logic             rd_valid,
   output alu_req_type      alu_req,
   input  alu_rsp_type      alu_rsp
);

   localparam logic [ID_W:0]  TABLE_LIMIT = (ID_W + 1)'(TABLE_NODES);
   localparam logic [CNT_W-1:0] IDX_END   = CNT_W'(TABLE_NODES);

   state_type              state_ff, state_in;
   req_type                req_ff, req_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             miss_ff, miss_in;
   logic                   own_seen_ff, own_seen_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       emitted_ff, emitted_in;
   logic [TABLE_NODES-1:0] act_ff, act_in;
   logic [31:0]            diff_ff, diff_in;
   logic                   hit_valid_ff, hit_valid_in;

   logic             out_free;
   logic             idx_end;
   logic [IDX_W-1:0] idx_slot;
   logic             own_in_table;
   logic             req_in_table;
   logic             req_is_own;
   logic             emit_last;
   logic             eop;
   logic             had_records;
   logic [7:0]       miss_inc;
   logic             active;

   // Shared decodes.
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign idx_end      = (idx_ff == IDX_END);
   assign idx_slot     = idx_ff[IDX_W-1:0];
   assign own_in_table = ({1'b0, cfg.own_id} < TABLE_LIMIT);
   assign req_in_table = ({1'b0, req_data.node_id} < TABLE_LIMIT);
   assign req_is_own   = (req_data.node_id == cfg.own_id);
   assign emit_last    = ((emitted_ff + CNT_W'(1)) == count_ff);
   assign had_records  = (req_ff.opcode == OP_RECORD);
   assign eop          = (had_records && req_ff.packet_last) || (req_ff.opcode == OP_EMPTY);
   assign miss_inc     = (miss_ff != MISS_MAX) ? miss_ff + 8'd1 : miss_ff;
   assign active       = hit_valid_ff && (diff_ff[31] || alu_rsp.borrow);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_data.opcode)
                  OP_RECORD: begin
                     if (!req_is_own && req_in_table) begin
                        state_in = ST_REC_READ;
                     end else begin
                        state_in = ST_STATUS;
                     end
                  end
                  OP_EMPTY: state_in = ST_STATUS;
                  OP_TICK:  state_in = ST_OWN;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_REC_READ: state_in = ST_REC_CMP;
         ST_REC_CMP:  state_in = ST_STATUS;
         ST_STATUS: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_OWN: state_in = ST_ACT_RD;
         ST_ACT_RD: begin
            if (!idx_end) begin
               state_in = ST_ACT_DIFF;
            end else if (count_ff == '0) begin
               state_in = ST_NONE;
            end else begin
               state_in = ST_EMIT_RD;
            end
         end
         ST_ACT_DIFF: state_in = ST_ACT_CMP;
         ST_ACT_CMP:  state_in = ST_ACT_RD;
         ST_NONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_RD: begin
            if (idx_end) begin
               state_in = ST_IDLE;
            end else if (act_ff[idx_slot]) begin
               state_in = ST_EMIT_OUT;
            end
         end
         ST_EMIT_OUT: begin
            if (out_free) begin
               state_in = emit_last ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath, table commands and result loading per state.
   always_comb begin
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      miss_in      = miss_ff;
      own_seen_in  = own_seen_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      emitted_in   = emitted_ff;
      act_in       = act_ff;
      diff_in      = diff_ff;
      hit_valid_in = hit_valid_ff;
      tbl_cmd      = '0;
      tbl_addr     = '0;
      alu_req      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               if (req_data.opcode == OP_RECORD && req_is_own) begin
                  own_seen_in = 1'b1;
               end
            end
         end
         ST_REC_READ: begin
            tbl_cmd.rd_en = 1'b1;
            tbl_addr      = req_ff.node_id[IDX_W-1:0];
         end
         ST_REC_CMP: begin
            // Store when the slot is empty, the timestamp is newer or the lifetime differs.
            alu_req.a = rd_data.stamp;
            alu_req.b = req_ff.record_time;
            tbl_addr  = req_ff.node_id[IDX_W-1:0];
            if (!rd_valid || alu_rsp.borrow || (rd_data.lref != req_ff.record_ref)) begin
               tbl_cmd.wr_en           = 1'b1;
               tbl_cmd.wr_data.stamp   = req_ff.record_time;
               tbl_cmd.wr_data.lref    = req_ff.record_ref;
               tbl_cmd.wr_data.source  = req_ff.record_origin || (rd_valid && rd_data.source);
               tbl_cmd.wr_data.arrival = req_ff.now_ms;
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               rsp_in       = '0;
               rsp_in.kind  = KIND_STATUS;
               rsp_in.last  = 1'b1;
               rsp_valid_in = 1'b1;
               if (eop) begin
                  own_seen_in = 1'b0;
                  if (own_seen_ff || !had_records) begin
                     miss_in = '0;
                  end else begin
                     miss_in                = miss_inc;
                     rsp_in.restart_request = (miss_inc > cfg.threshold);
                  end
               end
            end
         end
         ST_OWN: begin
            // Refresh the own entry before the walk sees it.
            if (own_in_table) begin
               tbl_cmd.wr_en           = 1'b1;
               tbl_addr                = cfg.own_id[IDX_W-1:0];
               tbl_cmd.wr_data.stamp   = req_ff.now_ms;
               tbl_cmd.wr_data.lref    = cfg.own_lref;
               tbl_cmd.wr_data.source  = 1'b1;
               tbl_cmd.wr_data.arrival = req_ff.now_ms;
            end
            idx_in   = '0;
            count_in = '0;
         end
         ST_ACT_RD: begin
            if (idx_end) begin
               idx_in     = '0;
               emitted_in = '0;
            end else begin
               tbl_cmd.rd_en = 1'b1;
               tbl_addr      = idx_slot;
            end
         end
         ST_ACT_DIFF: begin
            alu_req.a    = req_ff.now_ms;
            alu_req.b    = rd_data.arrival;
            diff_in      = alu_rsp.diff;
            hit_valid_in = rd_valid;
         end
         ST_ACT_CMP: begin
            // A negative age counts as active; otherwise compare against the timeout.
            alu_req.a        = {1'b0, diff_ff[30:0]};
            alu_req.b        = {1'b0, cfg.timeout};
            act_in[idx_slot] = active;
            count_in         = count_ff + CNT_W'(active);
            idx_in           = idx_ff + CNT_W'(1);
         end
         ST_NONE: begin
            if (out_free) begin
               rsp_in       = '0;
               rsp_in.kind  = KIND_IDLE;
               rsp_in.last  = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         ST_EMIT_RD: begin
            if (!idx_end) begin
               if (act_ff[idx_slot]) begin
                  tbl_cmd.rd_en = 1'b1;
                  tbl_addr      = idx_slot;
               end else begin
                  idx_in = idx_ff + CNT_W'(1);
               end
            end
         end
         ST_EMIT_OUT: begin
            // Send one relay record and clear its source flag in the same cycle.
            tbl_addr = idx_slot;
            if (out_free) begin
               rsp_in.kind            = KIND_RELAY;
               rsp_in.out_node_id     = ID_W'(idx_ff);
               rsp_in.out_time        = rd_data.stamp;
               rsp_in.out_ref         = rd_data.lref;
               rsp_in.relay_origin    = ((ID_W + 1)'(idx_ff) == {1'b0, cfg.own_id});
               rsp_in.source_heard    = rd_data.source;
               rsp_in.active_count    = 5'(count_ff);
               rsp_in.restart_request = 1'b0;
               rsp_in.last            = emit_last;
               rsp_valid_in           = 1'b1;
               tbl_cmd.wr_en          = 1'b1;
               tbl_cmd.wr_data        = rd_data;
               tbl_cmd.wr_data.source = 1'b0;
               emitted_in             = emitted_ff + CNT_W'(1);
               idx_in                 = idx_ff + CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // Control state is reset; payload registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         miss_ff      <= '0;
         own_seen_ff  <= 1'b0;
         idx_ff       <= '0;
         count_ff     <= '0;
         emitted_ff   <= '0;
         act_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         miss_ff      <= miss_in;
         own_seen_ff  <= own_seen_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         emitted_ff   <= emitted_in;
         act_ff       <= act_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      rsp_ff       <= rsp_in;
      diff_ff      <= diff_in;
      hit_valid_ff <= hit_valid_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The table port never reads and writes in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      !(tbl_cmd.rd_en && tbl_cmd.wr_en))
      else $error("table read and write issued together");

   // The relay walk never tries to emit more records than it counted.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_RD || state_ff == ST_EMIT_OUT) |-> (emitted_ff < count_ff))
      else $error("relay walk ran past the active count");

   // A packet end always leaves the own-id flag cleared.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STATUS && out_free && eop) |=> !own_seen_ff)
      else $error("own-id flag survived a packet end");

   // The final relay record returns the sequencer to idle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_OUT && out_free && emit_last) |=> (state_ff == ST_IDLE))
      else $error("walk continued after the last relay record");

endmodule

FILE: rtl/mesh_node_table_aging_core.sv
// Mesh node table with aging: a record for a table slot is read, compared, stored and
// gets a status result; a record for the own id or an id outside the table, and an empty
// packet, go straight to the status result. A tick refreshes the own entry, tests each
// entry through the shared subtractor (read, age difference, timeout compare), walks the
// table to the last active entry and relays each active one, or gives an idle result. One
// item is in work at a time; result stalls hold it. Reset clears all valid bits at once.
module mesh_node_table_aging_core
   import mntag_pkg::*;
#(
   parameter int TABLE_NODES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IDX_W = $clog2(TABLE_NODES);

   cfg_type          cfg_ff, cfg_in;
   logic             csr_write;
   logic [1:0]       csr_index;
   tbl_cmd_type      tbl_cmd;
   logic [IDX_W-1:0] tbl_addr;
   entry_type        rd_data;
   logic             rd_valid;
   alu_req_type      alu_req;
   alu_rsp_type      alu_rsp;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_OWN_ID:    cfg_in.own_id    = csr_pwdata[6:0];
            REG_OWN_LREF:  cfg_in.own_lref  = csr_pwdata[15:0];
            REG_TIMEOUT:   cfg_in.timeout   = csr_pwdata[30:0];
            REG_THRESHOLD: cfg_in.threshold = csr_pwdata[7:0];
            default:       cfg_in           = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_id    <= '0;
         cfg_ff.own_lref  <= '0;
         cfg_ff.timeout   <= TIMEOUT_RESET;
         cfg_ff.threshold <= THRESHOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register readback.
   always_comb begin
      unique case (csr_index)
         REG_OWN_ID:    csr_prdata = 32'(cfg_ff.own_id);
         REG_OWN_LREF:  csr_prdata = 32'(cfg_ff.own_lref);
         REG_TIMEOUT:   csr_prdata = 32'(cfg_ff.timeout);
         REG_THRESHOLD: csr_prdata = 32'(cfg_ff.threshold);
         default:       csr_prdata = '0;
      endcase
   end

   mntag_ctrl #(
      .TABLE_NODES (TABLE_NODES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cfg       (cfg_ff),
      .tbl_cmd   (tbl_cmd),
      .tbl_addr  (tbl_addr),
      .rd_data   (rd_data),
      .rd_valid  (rd_valid),
      .alu_req   (alu_req),
      .alu_rsp   (alu_rsp)
   );

   mntag_store #(
      .TABLE_NODES (TABLE_NODES)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .tbl_cmd  (tbl_cmd),
      .tbl_addr (tbl_addr),
      .rd_data  (rd_data),
      .rd_valid (rd_valid)
   );

   mntag_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

endmodule
